FILE: rtl/fckm_pkg.sv
// ----------------------------------------------------------------------------
// fckm_pkg
// Shared constants and helpers for the FASTA canonical k-mer stream block.
// ----------------------------------------------------------------------------
package fckm_pkg;

  localparam int          BYTE_W     = 8;
  localparam int          KLEN_W     = 5;
  localparam int          MAX_K_DEF  = 31;
  localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd18;

  // Characters of interest in the text stream
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_GT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_UA = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UC = 8'h43;
  localparam logic [BYTE_W-1:0] CH_UG = 8'h47;
  localparam logic [BYTE_W-1:0] CH_UT = 8'h54;
  localparam logic [BYTE_W-1:0] CH_LA = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LC = 8'h63;
  localparam logic [BYTE_W-1:0] CH_LG = 8'h67;
  localparam logic [BYTE_W-1:0] CH_LT = 8'h74;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_t;

  // Map a nucleotide letter (either case) to its 2-bit code
  function automatic base_t base_decode(input logic [BYTE_W-1:0] ch);
    base_t b;
    b.ok   = 1'b1;
    b.code = BASE_A;
    case (ch)
      CH_UA, CH_LA: b.code = BASE_A;
      CH_UC, CH_LC: b.code = BASE_C;
      CH_UG, CH_LG: b.code = BASE_G;
      CH_UT, CH_LT: b.code = BASE_T;
      default: b.ok = 1'b0;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/fckm_window.sv
// ----------------------------------------------------------------------------
// fckm_window
// Line parser and rolling forward / reverse-complement window with k-mer length
// register; registers both codes on each accepted byte and flags full windows.
// ----------------------------------------------------------------------------
module fckm_window
  import fckm_pkg::*;
#(
  parameter int MAX_K  = MAX_K_DEF,
  parameter int CODE_W = 2 * MAX_K
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [KLEN_W-1:0] cfg_wr_data,
  input  logic              in_accept,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              advance,
  output logic              win_valid,
  output logic [CODE_W-1:0] win_fwd,
  output logic [CODE_W-1:0] win_rev
);

  localparam int RUN_W = $clog2(MAX_K + 1);

  logic [KLEN_W-1:0] kmer_length;
  logic              in_header;
  logic              at_line_start;
  logic [CODE_W-1:0] forward_code;
  logic [CODE_W-1:0] revcomp_code;
  logic [RUN_W-1:0]  valid_run;

  logic              in_header_next;
  logic              at_line_start_next;
  logic [CODE_W-1:0] forward_code_next;
  logic [CODE_W-1:0] revcomp_code_next;
  logic [RUN_W-1:0]  valid_run_next;
  logic              complete;

  logic [KLEN_W-1:0] k_eff;
  logic [RUN_W-1:0]  k_run;
  logic [CODE_W-1:0] mask;
  logic [CODE_W-1:0] fwd_shift;
  logic [CODE_W-1:0] rev_shift;
  logic [CODE_W-1:0] rev_ins;
  base_t             base;

  // Clamp k into 1..MAX_K
  always_comb begin
    k_eff = kmer_length;
    if (kmer_length == '0) begin
      k_eff = KLEN_W'(1);
    end else if (kmer_length > KLEN_W'(MAX_K)) begin
      k_eff = KLEN_W'(MAX_K);
    end
    k_run = RUN_W'(k_eff);
  end

  assign base      = base_decode(in_byte);
  assign fwd_shift = {forward_code[CODE_W-3:0], base.code};
  assign rev_shift = revcomp_code >> 2;

  // Per base pair: keep pairs below k, insert complement at pair k-1
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      mask[2*i +: 2]    = (i < k_run) ? 2'b11 : 2'b00;
      rev_ins[2*i +: 2] = (i + 1 == k_run) ? ~base.code : rev_shift[2*i +: 2];
    end
  end

  always_comb begin
    in_header_next     = in_header;
    at_line_start_next = at_line_start;
    forward_code_next  = forward_code;
    revcomp_code_next  = revcomp_code;
    valid_run_next     = valid_run;
    complete           = 1'b0;
    if (in_byte == CH_LF) begin
      in_header_next     = 1'b0;
      at_line_start_next = 1'b1;
    end else if (in_header) begin
      in_header_next = 1'b1;
    end else if (at_line_start && in_byte == CH_GT) begin
      in_header_next     = 1'b1;
      at_line_start_next = 1'b0;
    end else begin
      at_line_start_next = 1'b0;
      if (!base.ok) begin
        forward_code_next = '0;
        revcomp_code_next = '0;
        valid_run_next    = '0;
      end else begin
        forward_code_next = fwd_shift & mask;
        revcomp_code_next = rev_ins & mask;
        valid_run_next    = (valid_run < k_run) ? valid_run + RUN_W'(1) : k_run;
        complete          = (valid_run_next == k_run);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length   <= KLEN_RESET;
      in_header     <= 1'b0;
      at_line_start <= 1'b1;
      forward_code  <= '0;
      revcomp_code  <= '0;
      valid_run     <= '0;
    end else if (cfg_wr_en) begin
      kmer_length  <= cfg_wr_data;
      forward_code <= '0;
      revcomp_code <= '0;
      valid_run    <= '0;
    end else if (in_accept) begin
      in_header     <= in_header_next;
      at_line_start <= at_line_start_next;
      forward_code  <= forward_code_next;
      revcomp_code  <= revcomp_code_next;
      valid_run     <= valid_run_next;
    end
  end

  // Window stage register; holds while the result side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (advance) begin
      win_valid <= in_accept && complete;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      win_fwd <= forward_code_next;
      win_rev <= revcomp_code_next;
    end
  end

endmodule

FILE: rtl/fasta_canonical_kmer_stream_top.sv
// ----------------------------------------------------------------------------
// fasta_canonical_kmer_stream_top
// Pipeline: two register stages (window, then result reg); the byte that
//   completes a k-mer is registered in the window, then in the result reg.
// Throughput: one text byte per cycle while the output keeps up; s_tready
//   drops only while a k-mer waits in the result register with m_tready low.
// Reset (rst, synchronous): k returns to 18, window and line state clear,
//   no k-mer is remembered for dedup, and m_tvalid drops.
// ----------------------------------------------------------------------------
module fasta_canonical_kmer_stream_top
  import fckm_pkg::*;
#(
  parameter int MAX_K = MAX_K_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // k-mer length register
  input  logic                                 cfg_wr_en,
  input  logic [KLEN_W-1:0]                    cfg_wr_data,
  // text bytes in
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [BYTE_W-1:0]                    s_tdata,  // [7:0] text_byte
  // canonical k-mers out
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((2*MAX_K+7)/8)*8-1:0]         m_tdata   // [2*MAX_K-1:0] canonical_code
);

  localparam int CODE_W  = 2 * MAX_K;
  localparam int TDATA_W = ((CODE_W + 7) / 8) * 8;

  logic              advance;
  logic              in_accept;
  logic              win_valid;
  logic [CODE_W-1:0] win_fwd;
  logic [CODE_W-1:0] win_rev;
  logic [CODE_W-1:0] canon;
  logic              emit;
  logic [CODE_W-1:0] last_emitted;
  logic              have_last;

  // The result register frees whenever it is empty or being taken; the whole
  // pipe moves on that condition, so a new byte can enter every cycle as long
  // as the output word is taken; hold everything while it waits.
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign in_accept = s_tvalid && s_tready;

  fckm_window #(
    .MAX_K  (MAX_K),
    .CODE_W (CODE_W)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_accept   (in_accept),
    .in_byte     (s_tdata),
    .advance     (advance),
    .win_valid   (win_valid),
    .win_fwd     (win_fwd),
    .win_rev     (win_rev)
  );

  // Canonical form: smaller of the two strands. Drop it if it repeats the
  // last k-mer sent; dedup memory survives length changes and headers.
  assign canon = (win_fwd <= win_rev) ? win_fwd : win_rev;
  assign emit  = win_valid && !(have_last && canon == last_emitted);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      have_last <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
      if (emit) begin
        have_last <= 1'b1;
      end
    end
  end

  // Payload: no reset needed, gated by m_tvalid / have_last
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_tdata      <= TDATA_W'(canon);
      last_emitted <= canon;
    end
  end

endmodule
